// File: src/efws_pkg.sv
// ----------------------------------------------------------------------------
// efws_pkg
// Shared widths and constants for the earliest-free worker scheduler.
// ----------------------------------------------------------------------------
package efws_pkg;

  localparam int unsigned CFG_W     = 9;
  localparam int unsigned LEN_W     = 32;
  localparam int unsigned TIME_W    = 63;
  localparam int unsigned OUT_ID_W  = 8;
  localparam int unsigned EPOCH_W   = 8;
  localparam int unsigned M_TDATA_W = 72;

  localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

endpackage

// File: src/efws_heap_ram.sv
// ----------------------------------------------------------------------------
// efws_heap_ram
// Heap storage: one write port, two registered read ports. Each entry carries
// an epoch tag; an entry whose tag differs from the current epoch reads as
// free time zero owned by the worker of the same slot index.
// ----------------------------------------------------------------------------
module efws_heap_ram
  import efws_pkg::*;
#(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic               clk_i,
  input  logic [EPOCH_W-1:0] epoch_i,
  input  logic               we_i,
  input  logic [AW-1:0]      waddr_i,
  input  logic [TIME_W-1:0]  wtime_i,
  input  logic [AW-1:0]      wid_i,
  input  logic [AW-1:0]      raddr_a_i,
  input  logic [AW-1:0]      raddr_b_i,
  output logic [TIME_W-1:0]  rtime_a_o,
  output logic [AW-1:0]      rid_a_o,
  output logic [TIME_W-1:0]  rtime_b_o,
  output logic [AW-1:0]      rid_b_o
);

  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [TIME_W-1:0]  ftime;
    logic [AW-1:0]      wid;
  } entry_t;

  entry_t        mem [DEPTH];
  entry_t        rd_a_q, rd_b_q;
  logic [AW-1:0] raddr_a_q, raddr_b_q;
  logic          vld_a, vld_b;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= '{tag: epoch_i, ftime: wtime_i, wid: wid_i};
    end
    rd_a_q    <= mem[raddr_a_i];
    rd_b_q    <= mem[raddr_b_i];
    raddr_a_q <= raddr_a_i;
    raddr_b_q <= raddr_b_i;
  end

  assign vld_a     = (rd_a_q.tag == epoch_i);
  assign vld_b     = (rd_b_q.tag == epoch_i);
  assign rtime_a_o = vld_a ? rd_a_q.ftime : '0;
  assign rid_a_o   = vld_a ? rd_a_q.wid : raddr_a_q;
  assign rtime_b_o = vld_b ? rd_b_q.ftime : '0;
  assign rid_b_o   = vld_b ? rd_b_q.wid : raddr_b_q;

endmodule

// File: src/earliest_free_worker_scheduler_top.sv
// ----------------------------------------------------------------------------
// earliest_free_worker_scheduler_top
// Assigns each job beat to the worker that becomes free earliest, ties to the
// lower worker index, using a binary min-heap of (free time, worker) pairs.
// ----------------------------------------------------------------------------
// Each job passes through these steps before the next job can be taken:
// the root is read, then updated and the result beat emitted, then for each
// heap level the updated root sinks (at most floor(log2(worker_count))) there
// is a memory read step and a compare/write step of the key comparators.
// After reset the heap memory is swept over all MAX_WORKERS entries before
// the first job is taken; a first_job beat bumps an epoch tag, and every
// 256th such beat triggers the same full sweep.
// Results sit in an output register, so the input side never waits for the
// result to be taken except while the next root update is pending.
module earliest_free_worker_scheduler_top
  import efws_pkg::*;
#(
  parameter int unsigned MAX_WORKERS = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [LEN_W-1:0]     s_axis_tdata,   // [31:0] job_length
  input  logic [0:0]           s_axis_tuser,   // [0] first_job
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,   // [7:0] chosen_worker, [70:8] start_time
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_W-1:0]     cfg_data_i      // worker_count
);

  localparam int unsigned AW  = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int unsigned IXW = (AW + 2 > CFG_W) ? AW + 2 : CFG_W;
  localparam int unsigned KW  = TIME_W + AW;

  typedef enum logic [5:0] {
    ST_SWEEP = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_START = 6'b000100,
    ST_ROOT  = 6'b001000,
    ST_RD    = 6'b010000,
    ST_CMP   = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  logic [EPOCH_W-1:0]   epoch_q, epoch_d;
  logic [CFG_W-1:0]     wcount_q;
  logic [IXW-1:0]       n_q, n_d;
  logic [LEN_W-1:0]     len_q, len_d;
  logic                 pend_q, pend_d;
  logic [AW-1:0]        sw_cnt_q, sw_cnt_d;
  logic [AW-1:0]        pos_q, pos_d;
  logic [TIME_W-1:0]    cur_time_q, cur_time_d;
  logic [AW-1:0]        cur_id_q, cur_id_d;
  logic                 m_valid_q, m_valid_d;
  logic [M_TDATA_W-1:0] m_data_q, m_data_d;

  logic                 we;
  logic [AW-1:0]        waddr, wid, raddr_a;
  logic [TIME_W-1:0]    wtime;
  logic [TIME_W-1:0]    rtime_a, rtime_b;
  logic [AW-1:0]        rid_a, rid_b;

  logic [IXW-1:0]       l_idx, r_idx;
  logic                 l_ok, r_ok;
  logic [KW-1:0]        key_c, key_l, key_r;
  logic                 lt_lc, lt_rc, lt_rl, sel_l, sel_r;
  logic [TIME_W:0]      sum;
  logic [TIME_W-1:0]    new_time;
  logic                 in_acc;

  assign l_idx   = IXW'({pos_q, 1'b1});
  assign r_idx   = l_idx + IXW'(1);
  assign l_ok    = (l_idx < n_q);
  assign r_ok    = (r_idx < n_q);
  assign raddr_a = (state_q == ST_START) ? '0 : l_idx[AW-1:0];

  efws_heap_ram #(
    .DEPTH(MAX_WORKERS),
    .AW   (AW)
  ) u_ram (
    .clk_i    (clk_i),
    .epoch_i  (epoch_q),
    .we_i     (we),
    .waddr_i  (waddr),
    .wtime_i  (wtime),
    .wid_i    (wid),
    .raddr_a_i(raddr_a),
    .raddr_b_i(r_idx[AW-1:0]),
    .rtime_a_o(rtime_a),
    .rid_a_o  (rid_a),
    .rtime_b_o(rtime_b),
    .rid_b_o  (rid_b)
  );

  // key comparators: (free time, worker) ordering
  assign key_c = {cur_time_q, cur_id_q};
  assign key_l = {rtime_a, rid_a};
  assign key_r = {rtime_b, rid_b};
  assign lt_lc = (key_l < key_c);
  assign lt_rc = (key_r < key_c);
  assign lt_rl = (key_r < key_l);
  assign sel_l = l_ok && lt_lc;
  assign sel_r = r_ok && (sel_l ? lt_rl : lt_rc);

  assign sum      = {1'b0, rtime_a} + (TIME_W + 1)'(len_q);
  assign new_time = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];

  assign in_acc = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d    = state_q;
    epoch_d    = epoch_q;
    n_d        = n_q;
    len_d      = len_q;
    pend_d     = pend_q;
    sw_cnt_d   = sw_cnt_q;
    pos_d      = pos_q;
    cur_time_d = cur_time_q;
    cur_id_d   = cur_id_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_data_d   = m_data_q;
    we         = 1'b0;
    waddr      = pos_q;
    wtime      = cur_time_q;
    wid        = cur_id_q;

    case (state_q)
      ST_SWEEP: begin
        we       = 1'b1;
        waddr    = sw_cnt_q;
        wtime    = '0;
        wid      = sw_cnt_q;
        sw_cnt_d = sw_cnt_q + AW'(1);
        if (sw_cnt_q == AW'(MAX_WORKERS - 1)) begin
          sw_cnt_d = '0;
          pend_d   = 1'b0;
          state_d  = pend_q ? ST_START : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          len_d = s_axis_tdata;
          pos_d = '0;
          if (wcount_q == '0) begin
            n_d = IXW'(1);
          end else if (IXW'(wcount_q) > IXW'(MAX_WORKERS)) begin
            n_d = IXW'(MAX_WORKERS);
          end else begin
            n_d = IXW'(wcount_q);
          end
          state_d = ST_START;
          if (s_axis_tuser[0]) begin
            if (epoch_q == EPOCH_MAX) begin
              epoch_d  = '0;
              sw_cnt_d = '0;
              pend_d   = 1'b1;
              state_d  = ST_SWEEP;
            end else begin
              epoch_d = epoch_q + EPOCH_W'(1);
            end
          end
        end
      end
      ST_START: begin
        if (!m_valid_q || m_axis_tready) begin
          state_d = ST_ROOT;
        end
      end
      ST_ROOT: begin
        cur_time_d = new_time;
        cur_id_d   = rid_a;
        m_valid_d  = 1'b1;
        m_data_d   = {1'b0, rtime_a, OUT_ID_W'(rid_a)};
        state_d    = ST_CMP;
      end
      ST_RD: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        we = 1'b1;
        if (sel_r) begin
          wtime   = rtime_b;
          wid     = rid_b;
          pos_d   = r_idx[AW-1:0];
          state_d = ST_RD;
        end else if (sel_l) begin
          wtime   = rtime_a;
          wid     = rid_a;
          pos_d   = l_idx[AW-1:0];
          state_d = ST_RD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_SWEEP;
      epoch_q   <= '0;
      wcount_q  <= CFG_W'(1);
      pend_q    <= 1'b0;
      sw_cnt_q  <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      epoch_q   <= epoch_d;
      pend_q    <= pend_d;
      sw_cnt_q  <= sw_cnt_d;
      m_valid_q <= m_valid_d;
      if (cfg_valid_i) begin
        wcount_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    len_q      <= len_d;
    pos_q      <= pos_d;
    cur_time_q <= cur_time_d;
    cur_id_q   <= cur_id_d;
    m_data_q   <= m_data_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign cfg_ready_o   = 1'b1;

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// earliest_free_worker_scheduler_top testbench
// Drives job beats and worker_count writes into the scheduler. Every job beat
// is run through an in-bench min-heap that keeps its own (free time, worker)
// slots, and each result beat is checked against the oldest prediction. A
// directed table covers reset, ties, flushes and the count limits. Random
// phases follow, each with its own worker count and flush rate. Both sides
// take random gaps, and one phase holds the result side off for a long time.
// ----------------------------------------------------------------------------
module testbench;
  import efws_pkg::*;

  localparam int unsigned WORKERS_MAX = 256;
  localparam int unsigned SETTLE      = 24;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned RANDOM_JOBS = 1030;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef enum logic {ROW_CFG, ROW_JOB} row_kind_e;

  typedef struct {
    row_kind_e        kind;
    logic [CFG_W-1:0] count;
    logic [LEN_W-1:0] len;
    logic             first;
    bit               typed;
    logic [OUT_ID_W-1:0] worker;
    logic [TIME_W-1:0]   start;
  } row_t;

  typedef struct {
    logic [OUT_ID_W-1:0] worker;
    logic [TIME_W-1:0]   start;
  } assign_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [LEN_W-1:0]     s_axis_tdata;
  logic [0:0]           s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_W-1:0]     cfg_data_i;

  logic [TIME_W-1:0]   slot_free   [WORKERS_MAX];
  logic [OUT_ID_W-1:0] slot_worker [WORKERS_MAX];
  logic [CFG_W-1:0]    worker_count_q;
  assign_t             assign_q [$];
  int                  errors = 0;
  int                  stall_cycles = 0;
  bit                  rx_hold_req;

  earliest_free_worker_scheduler_top #(
    .MAX_WORKERS(WORKERS_MAX)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---- heap predictor ----
  function automatic void clear_slots();
    for (int i = 0; i < WORKERS_MAX; i++) begin
      slot_free[i]   = '0;
      slot_worker[i] = OUT_ID_W'(i);
    end
  endfunction

  function automatic bit slot_lt(int unsigned a, int unsigned b);
    if (slot_free[a] != slot_free[b]) return slot_free[a] < slot_free[b];
    return slot_worker[a] < slot_worker[b];
  endfunction

  function automatic assign_t assign_job(logic [LEN_W-1:0] len, logic first);
    int unsigned         n, pos, best, l, r;
    assign_t             res;
    logic [TIME_W-1:0]   t;
    logic [OUT_ID_W-1:0] w;
    n = worker_count_q;
    if (n < 1) n = 1;
    if (n > WORKERS_MAX) n = WORKERS_MAX;
    if (first) clear_slots();
    res.worker = slot_worker[0];
    res.start  = slot_free[0];
    if (TIME_W'(len) > TIME_MAX - slot_free[0]) slot_free[0] = TIME_MAX;
    else slot_free[0] = slot_free[0] + TIME_W'(len);
    pos = 0;
    forever begin
      best = pos;
      l    = 2 * pos + 1;
      r    = l + 1;
      if (l < n && slot_lt(l, best)) best = l;
      if (r < n && slot_lt(r, best)) best = r;
      if (best == pos) break;
      t = slot_free[pos];
      w = slot_worker[pos];
      slot_free[pos]    = slot_free[best];
      slot_worker[pos]  = slot_worker[best];
      slot_free[best]   = t;
      slot_worker[best] = w;
      pos = best;
    end
    return res;
  endfunction

  // ---- stimulus helpers ----
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic row_t cfg_row(logic [CFG_W-1:0] count);
    row_t row;
    row = '{kind: ROW_CFG, count: count, len: '0, first: 1'b0, typed: 1'b0,
            worker: '0, start: '0};
    return row;
  endfunction

  function automatic row_t job_row(logic [LEN_W-1:0] len, logic first, bit typed,
                                   logic [OUT_ID_W-1:0] worker,
                                   logic [TIME_W-1:0] start);
    row_t row;
    row = '{kind: ROW_JOB, count: '0, len: len, first: first, typed: typed,
            worker: worker, start: start};
    return row;
  endfunction

  task automatic run_job(input logic [LEN_W-1:0] len, input logic first,
                         input int gap, input bit typed,
                         input logic [OUT_ID_W-1:0] worker,
                         input logic [TIME_W-1:0] start);
    assign_t pred;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= len;
    s_axis_tuser  <= first;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pred = assign_job(len, first);
    if (typed) begin
      pred.worker = worker;
      pred.start  = start;
    end
    assign_q.push_back(pred);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // wait out all results plus the tail of the last sift before touching config
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (assign_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_worker_count(input logic [CFG_W-1:0] count);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= count;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i    <= 1'b0;
    worker_count_q = count;
  endtask

  // ---- result side ----
  initial begin : result_ready
    int run, gap;
    bit held;
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (rx_hold_req && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      run = $urandom_range(1, 30);
      m_axis_tready <= 1'b1;
      repeat (run) @(posedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : check_assignment
    assign_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (assign_q.size() == 0) begin
        $error("result beat with no job pending");
        errors++;
      end else begin
        want = assign_q.pop_front();
        if (m_axis_tdata[7:0] !== want.worker) begin
          $error("chosen_worker: expected %0d, got %0d", want.worker, m_axis_tdata[7:0]);
          errors++;
        end
        if (m_axis_tdata[70:8] !== want.start) begin
          $error("start_time: expected %0d, got %0d", want.start, m_axis_tdata[70:8]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("earliest_free_worker_scheduler_top regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---- main sequence ----
  initial begin : stimulus
    row_t             plan [$];
    int               sent, phase, span, rate, r, i;
    logic [LEN_W-1:0] len;
    logic             first;
    logic [CFG_W-1:0] count;
    bit               calm;
    rx_hold_req    = 1'b0;
    worker_count_q = 9'd1;
    clear_slots();
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    plan = '{
      job_row(32'd5, 1'b0, 1, 8'd0, 63'd0),
      job_row(32'hFFFF_FFFF, 1'b0, 1, 8'd0, 63'd5),
      cfg_row(9'd0),
      job_row(32'd1, 1'b1, 1, 8'd0, 63'd0),
      cfg_row(9'd3),
      job_row(32'd10, 1'b0, 0, '0, '0),
      job_row(32'd10, 1'b1, 1, 8'd0, 63'd0),
      job_row(32'd10, 1'b0, 1, 8'd1, 63'd0),
      job_row(32'd10, 1'b0, 1, 8'd2, 63'd0),
      job_row(32'd0, 1'b0, 1, 8'd0, 63'd10),
      job_row(32'd1, 1'b0, 1, 8'd0, 63'd10),
      job_row(32'd0, 1'b0, 1, 8'd1, 63'd10),
      cfg_row(9'd511),
      job_row(32'hFFFF_FFFF, 1'b1, 1, 8'd0, 63'd0),
      job_row(32'd0, 1'b0, 1, 8'd1, 63'd0),
      cfg_row(9'd257),
      job_row(32'd7, 1'b0, 0, '0, '0),
      cfg_row(9'd256),
      job_row(32'd0, 1'b1, 1, 8'd0, 63'd0),
      cfg_row(9'd2),
      job_row(32'd3, 1'b0, 0, '0, '0),
      job_row(32'd3, 1'b0, 0, '0, '0),
      cfg_row(9'd1),
      job_row(32'hFFFF_FFFF, 1'b0, 0, '0, '0)
    };

    for (i = 0; i < plan.size(); i++) begin
      if (plan[i].kind == ROW_CFG) write_worker_count(plan[i].count);
      else run_job(plan[i].len, plan[i].first, pick_gap(), plan[i].typed,
                   plan[i].worker, plan[i].start);
    end

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_JOBS) begin
      r = $urandom_range(0, 99);
      if (r < 50)      count = CFG_W'($urandom_range(1, 8));
      else if (r < 70) count = CFG_W'($urandom_range(9, 40));
      else if (r < 80) count = 9'd256;
      else if (r < 85) count = 9'd0;
      else if (r < 90) count = CFG_W'($urandom_range(257, 511));
      else             count = CFG_W'($urandom_range(1, 511));
      write_worker_count(count);
      r = $urandom_range(0, 2);
      rate = (r == 0) ? 3 : (r == 1) ? 20 : 60;
      calm = ($urandom_range(0, 3) == 0);
      span = $urandom_range(15, 70);
      // keep offering beats for the whole receiver hold
      if (phase == 4) begin
        rx_hold_req = 1'b1;
        calm        = 1'b1;
        span        = 70;
      end
      for (int k = 0; k < span && sent < RANDOM_JOBS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 15)      len = '0;
        else if (r < 25) len = '1;
        else if (r < 55) len = LEN_W'($urandom_range(0, 15));
        else if (r < 70) len = LEN_W'($urandom_range(0, 1000));
        else             len = $urandom;
        if (k == 0) first = ($urandom_range(0, 99) < 75);
        else        first = ($urandom_range(0, 99) < rate);
        run_job(len, first, calm ? 0 : pick_gap(), 0, '0, '0);
        sent++;
      end
      phase++;
    end

    drain_results();
    if (errors == 0) begin
      $display("earliest_free_worker_scheduler_top regression: pass");
    end else begin
      $display("earliest_free_worker_scheduler_top regression: fail");
    end
    $finish;
  end

endmodule
